// ----- rtl/core/lsac_pkg.sv -----
// Shared types and constants of the LRU set-associative cache model.
package lsac_pkg;

    localparam int ADDR_W      = 32;
    localparam int TAG_W       = 32;
    localparam int CNT_W       = 32;
    localparam int SET_FIELD_W = 12;   // widest set index the block supports
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [3:0] RST_SET_BITS = 4'd4;
    localparam logic [3:0] RST_WAYS     = 4'd1;
    localparam logic [4:0] RST_OFFSET   = 5'd4;

    typedef enum logic [1:0] {
        CMD_IGNORE = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_STORE  = 2'd2,
        CMD_MODIFY = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd              command;
        logic [ADDR_W-1:0] address;
    } t_cache_in;

    typedef struct packed {
        logic [1:0]       hits_now;
        logic             misses_now;
        logic             evictions_now;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
    } t_cache_out;

    // Classified access handed from front to back
    typedef struct packed {
        t_cmd                   command;
        logic [SET_FIELD_W-1:0] set_idx;
        logic [TAG_W-1:0]       tag;
    } t_touch_req;

    typedef enum logic {
        BK_IDLE,
        BK_UPDATE
    } t_back_state;

endpackage

// ----- rtl/core/lsac_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lsac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/lsac_front.sv -----
// Front end: configuration registers, item acceptance and address split.
module lsac_front #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [lsac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lsac_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_start,
    input  logic                                i_full,
    input  lsac_pkg::t_cache_in                 i_item,
    output logic                                o_push,
    output lsac_pkg::t_touch_req                o_req,
    output logic [MAX_WAYS-1:0]                 o_way_mask
);
    import lsac_pkg::*;

    logic [3:0] r_set_bits;
    logic [3:0] r_ways;
    logic [4:0] r_offset;

    logic [3:0]        sb;
    logic [5:0]        tshift;
    logic [ADDR_W-1:0] shifted;
    logic [4:0]        ways_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= RST_SET_BITS;
            r_ways     <= RST_WAYS;
            r_offset   <= RST_OFFSET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SET_BITS: r_set_bits <= i_cfg_data[3:0];
                CFG_WAYS:     r_ways     <= i_cfg_data[3:0];
                CFG_OFFSET:   r_offset   <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // set index bits saturate at the maximum the store holds
    assign sb      = (r_set_bits > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : r_set_bits;
    assign tshift  = {1'b0, r_offset} + {2'b00, sb};
    assign shifted = i_item.address >> r_offset;

    assign ways_used = (r_ways == 4'd0) ? 5'd1 :
                       (({1'b0, r_ways} > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : {1'b0, r_ways});

    always_comb begin
        o_req         = '0;
        o_req.command = i_item.command;
        for (int j = 0; j < MAX_SET_BITS; j++) begin
            o_req.set_idx[j] = shifted[j] & (4'(j) < sb);
        end
        o_req.tag = tshift[5] ? '0 : (i_item.address >> tshift[4:0]);
    end

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            o_way_mask[i] = (5'(i) < ways_used);
        end
    end

    assign o_push = i_start & ~i_full;

endmodule

// ----- rtl/core/lsac_queue.sv -----
// Two-entry queue between front and back.
module lsac_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lsac_pkg::t_touch_req i_req,
    input  logic                 i_pop,
    output lsac_pkg::t_touch_req o_req,
    output logic                 o_empty,
    output logic                 o_full
);
    import lsac_pkg::*;

    t_touch_req r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_req   = r_slot[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule

// ----- rtl/core/lsac_back.sv -----
// Back end: per-set read-modify-write of tags and recency ranks, counters, result.
module lsac_back #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lsac_pkg::t_touch_req i_req,
    input  logic                 i_empty,
    input  logic [MAX_WAYS-1:0]  i_way_mask,
    output logic                 o_pop,
    output logic                 o_strobe,
    output lsac_pkg::t_cache_out o_result
);
    import lsac_pkg::*;

    localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W  = RANK_W;
    localparam int SETS   = 2 ** MAX_SET_BITS;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
    } t_line;

    localparam int ROW_W = MAX_WAYS * $bits(t_line);

    t_back_state r_state;
    t_back_state n_state;
    t_touch_req  r_cur;
    logic [SETS-1:0] r_row_valid;
    logic [CNT_W-1:0] r_hit_total;
    logic [CNT_W-1:0] r_miss_total;
    logic [CNT_W-1:0] r_evict_total;
    logic       r_strobe;
    t_cache_out r_result;

    logic ram_re;
    logic ram_we;
    logic [ROW_W-1:0] ram_rdata;
    logic [MAX_SET_BITS-1:0] cur_set;

    t_line [MAX_WAYS-1:0] row;
    t_line [MAX_WAYS-1:0] new_row;
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             inv_any;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W-1:0] victim;
    logic [RANK_W-1:0] best;
    logic [WAY_W-1:0] tw;
    logic [RANK_W-1:0] old_rank;
    logic             touch;
    logic [1:0]       hits_now;
    logic             misses_now;
    logic             evicts_now;

    assign cur_set = r_cur.set_idx[MAX_SET_BITS-1:0];

    lsac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cur_set),
        .i_wdata (new_row),
        .i_re    (ram_re),
        .i_raddr (i_req.set_idx[MAX_SET_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:   if (!i_empty) n_state = BK_UPDATE;
            BK_UPDATE: n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop  = 1'b0;
        ram_re = 1'b0;
        ram_we = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_pop  = ~i_empty;
                ram_re = ~i_empty;
            end
            BK_UPDATE: ram_we = touch;
            default: ;
        endcase
    end

    // hit search, fill slot, victim choice and rank update
    always_comb begin
        row      = r_row_valid[cur_set] ? ram_rdata : '0;
        hit      = 1'b0;
        hit_way  = '0;
        inv_any  = 1'b0;
        inv_way  = '0;
        victim   = '0;
        best     = row[0].rank;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (i_way_mask[i] && row[i].valid && row[i].tag == r_cur.tag && !hit) begin
                hit     = 1'b1;
                hit_way = WAY_W'(i);
            end
            if (i_way_mask[i] && !row[i].valid && !inv_any) begin
                inv_any = 1'b1;
                inv_way = WAY_W'(i);
            end
        end
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (i_way_mask[i] && row[i].rank > best) begin
                best   = row[i].rank;
                victim = WAY_W'(i);
            end
        end
        tw       = hit ? hit_way : (inv_any ? inv_way : victim);
        old_rank = row[tw].rank;
        new_row  = row;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (WAY_W'(i) != tw && i_way_mask[i] && row[i].valid &&
                (!hit || row[i].rank < old_rank) && row[i].rank < RANK_MAX) begin
                new_row[i].rank = row[i].rank + RANK_W'(1);
            end
        end
        new_row[tw].rank = '0;
        if (!hit) begin
            new_row[tw].valid = 1'b1;
            new_row[tw].tag   = r_cur.tag;
        end
    end

    // a modify's second touch always hits the line just made most recent
    assign touch      = (r_cur.command != CMD_IGNORE);
    assign hits_now   = touch ? ({1'b0, hit} + {1'b0, r_cur.command == CMD_MODIFY}) : 2'd0;
    assign misses_now = touch & ~hit;
    assign evicts_now = touch & ~hit & ~inv_any;

    always_ff @(posedge i_clk) begin
        if (r_state == BK_IDLE && !i_empty) begin
            r_cur <= i_req;
        end
        if (r_state == BK_UPDATE) begin
            r_result.hits_now       <= hits_now;
            r_result.misses_now     <= misses_now;
            r_result.evictions_now  <= evicts_now;
            r_result.hit_total      <= r_hit_total + CNT_W'(hits_now);
            r_result.miss_total     <= r_miss_total + CNT_W'(misses_now);
            r_result.eviction_total <= r_evict_total + CNT_W'(evicts_now);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= BK_IDLE;
            r_row_valid   <= '0;
            r_hit_total   <= '0;
            r_miss_total  <= '0;
            r_evict_total <= '0;
            r_strobe      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == BK_UPDATE);
            if (r_state == BK_UPDATE) begin
                r_hit_total   <= r_hit_total + CNT_W'(hits_now);
                r_miss_total  <= r_miss_total + CNT_W'(misses_now);
                r_evict_total <= r_evict_total + CNT_W'(evicts_now);
                if (touch) begin
                    r_row_valid[cur_set] <= 1'b1;
                end
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- rtl/core/lru_set_assoc_cache_model_core.sv -----
// Top level of the LRU set-associative cache model.
//
// Command channel: an access (command, address) transfers at a rising edge
// with start high and busy low. Busy rises while the two-entry queue between
// the front end and the back end is full.
// Configuration channel: i_cfg_valid/o_cfg_ready with a register index
// (0 set index bits, 1 ways in use, 2 offset bits) and data; ready is always
// high. Write only while no access is in flight.
// Result channel: o_strobe is high for one cycle with o_result; the receiver
// cannot stall, so every result is delivered on that single cycle.
// Flow: with the queue empty, an accepted access is registered in the queue,
// its set row is read from the synchronous row RAM while the back end is idle,
// the row is updated and written back in the update state, and o_strobe then
// rises with the registered result. The back end takes no new access until
// the row update is done. A modify's second touch is folded into the same update.
// Reset: synchronous, active low. Configuration returns to 4/1/4, totals
// clear, and per-set valid flops make every row read as empty at once, so no
// clearing pass is needed.
module lru_set_assoc_cache_model_core #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lsac_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lsac_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // access commands
    input  logic                             start,
    output logic                             busy,
    input  lsac_pkg::t_cache_in              i_item,
    // results
    output logic                             o_strobe,
    output lsac_pkg::t_cache_out             o_result
);
    import lsac_pkg::*;

    logic                push;
    logic                pop;
    logic                q_empty;
    logic                q_full;
    t_touch_req          front_req;
    t_touch_req          head_req;
    logic [MAX_WAYS-1:0] way_mask;

    assign o_cfg_ready = 1'b1;
    assign busy        = q_full;

    // front: config registers, address split into set and tag
    lsac_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_start     (start),
        .i_full      (q_full),
        .i_item      (i_item),
        .o_push      (push),
        .o_req       (front_req),
        .o_way_mask  (way_mask)
    );

    // decouples acceptance from the set update
    lsac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .i_pop   (pop),
        .o_req   (head_req),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: set row read-modify-write, LRU ranks, running totals
    lsac_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (head_req),
        .i_empty    (q_empty),
        .i_way_mask (way_mask),
        .o_pop      (pop),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule
